### sv/mtc_pkg.sv
// Package of the Morse text codec: word types, codes, and the code tables.
package mtc_pkg;

    localparam int MaxCodeLen   = 7;
    localparam int TableEntries = 128;
    localparam int LenW         = $clog2(MaxCodeLen + 1);
    localparam int BitIdxW      = $clog2(MaxCodeLen);
    localparam int PathIdxW     = MaxCodeLen + 1;
    localparam int PathEntries  = 2 ** PathIdxW;
    localparam int QueueDepth   = 4;
    localparam int QueuePtrW    = $clog2(QueueDepth);
    localparam int CfgDataW     = 16;

    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CfgMode      = 2'd0;
    localparam t_cfg_index CfgMaxLength = 2'd1;
    localparam t_cfg_index CfgErrorChar = 2'd2;

    typedef logic [1:0] t_status;
    localparam t_status StatusOk       = 2'd0;
    localparam t_status StatusUnknown  = 2'd1;
    localparam t_status StatusOverflow = 2'd2;

    localparam logic [7:0] ChNul      = 8'h00;
    localparam logic [7:0] ChSpace    = 8'h20;
    localparam logic [7:0] ChDash     = 8'h2d;
    localparam logic [7:0] ChDot      = 8'h2e;
    localparam logic [7:0] ChOffTable = 8'hff;
    localparam logic [7:0] ChLowerA   = 8'h61;
    localparam logic [7:0] ChLowerZ   = 8'h7a;
    localparam logic [7:0] CaseOffset = 8'h20;

    localparam logic        ModeReset      = 1'b0;
    localparam logic [15:0] MaxLengthReset = 16'd255;
    localparam logic [7:0]  ErrorCharReset = 8'h3f;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
        t_status    out_status;
    } t_out_word;

    typedef struct packed {
        logic [LenW-1:0]       len;
        logic [MaxCodeLen-1:0] bits;
    } t_code;

    typedef struct packed {
        logic       exists;
        logic [6:0] ch;
    } t_path_entry;

    typedef t_path_entry [PathEntries-1:0] t_path_tab;

    typedef struct packed {
        logic       has_char;
        logic [7:0] char_byte;
        logic       sep;
        t_code      code;
        logic       has_end;
        t_status    status;
    } t_job;

    function automatic logic [8*MaxCodeLen-1:0] code_text(input logic [6:0] b);
        case (b)
            7'd33: code_text = "-.-.--";
            7'd34: code_text = ".-..-.";
            7'd36: code_text = "...-..-";
            7'd38: code_text = ".-...";
            7'd39: code_text = ".----.";
            7'd40: code_text = "-.--.";
            7'd41: code_text = "-.--.-";
            7'd43: code_text = ".-.-.";
            7'd44: code_text = "--..--";
            7'd45: code_text = "-....-";
            7'd46: code_text = ".-.-.-";
            7'd47: code_text = "-..-.";
            7'd48: code_text = "-----";
            7'd49: code_text = ".----";
            7'd50: code_text = "..---";
            7'd51: code_text = "...--";
            7'd52: code_text = "....-";
            7'd53: code_text = ".....";
            7'd54: code_text = "-....";
            7'd55: code_text = "--...";
            7'd56: code_text = "---..";
            7'd57: code_text = "----.";
            7'd58: code_text = "---...";
            7'd59: code_text = "-.-.-.";
            7'd61: code_text = "-...-";
            7'd63: code_text = "..--..";
            7'd64: code_text = ".--.-.";
            7'd65: code_text = ".-";
            7'd66: code_text = "-...";
            7'd67: code_text = "-.-.";
            7'd68: code_text = "-..";
            7'd69: code_text = ".";
            7'd70: code_text = "..-.";
            7'd71: code_text = "--.";
            7'd72: code_text = "....";
            7'd73: code_text = "..";
            7'd74: code_text = ".---";
            7'd75: code_text = "-.-";
            7'd76: code_text = ".-..";
            7'd77: code_text = "--";
            7'd78: code_text = "-.";
            7'd79: code_text = "---";
            7'd80: code_text = ".--.";
            7'd81: code_text = "--.-";
            7'd82: code_text = ".-.";
            7'd83: code_text = "...";
            7'd84: code_text = "-";
            7'd85: code_text = "..-";
            7'd86: code_text = "...-";
            7'd87: code_text = ".--";
            7'd88: code_text = "-..-";
            7'd89: code_text = "-.--";
            7'd90: code_text = "--..";
            7'd95: code_text = "..--.-";
            default: code_text = '0;
        endcase
    endfunction

    function automatic t_code code_entry(input logic [6:0] b);
        logic [8*MaxCodeLen-1:0] txt;
        int n;
        t_code c;
        txt = code_text(b);
        n = 0;
        for (int i = 0; i < MaxCodeLen; i++) begin
            if (txt[8*i +: 8] != ChNul) begin
                n = i + 1;
            end
        end
        c.len = LenW'(n);
        c.bits = '0;
        for (int k = 0; k < MaxCodeLen; k++) begin
            if (k < n) begin
                c.bits[k] = (txt[8*(n-1-k) +: 8] == ChDash);
            end
        end
        return c;
    endfunction

    function automatic t_code code_of(input logic [7:0] b);
        logic [7:0] u;
        u = b;
        if (b >= ChLowerA && b <= ChLowerZ) begin
            u = b - CaseOffset;
        end
        return code_entry(u[6:0]);
    endfunction

    function automatic t_path_tab build_path_tab();
        t_path_tab tab;
        t_code c;
        int plen;
        logic [MaxCodeLen-1:0] mask;
        logic [MaxCodeLen-1:0] pbits;
        for (int idx = 0; idx < PathEntries; idx++) begin
            tab[idx] = '0;
            plen = 0;
            for (int j = 0; j < PathIdxW; j++) begin
                if (((idx >> j) & 1) != 0) begin
                    plen = j;
                end
            end
            mask = MaxCodeLen'((1 << plen) - 1);
            pbits = MaxCodeLen'(idx) & mask;
            for (int b = 0; b < TableEntries; b++) begin
                c = code_of(8'(b));
                if (c.len != '0 && int'(c.len) >= plen && (c.bits & mask) == pbits) begin
                    tab[idx].exists = 1'b1;
                    if (int'(c.len) == plen) begin
                        tab[idx].ch = 7'(b);
                    end
                end
            end
        end
        return tab;
    endfunction

    localparam t_path_tab PathTab = build_path_tab();

endpackage

### sv/morse_text_codec_top.sv
// Top level of the Morse text codec: front, job queue and back.
// An accepted byte is registered in the job queue, then in the back's job and output
// registers. The back delivers one result word per cycle while results are popped; an
// encoded byte yields up to nine words, so the job queue of four entries sets how far
// input may run ahead. Decode sustains one byte per cycle while results are popped, half
// that when a final byte yields two words. Encoded bytes yield their symbols one at a time.
// Synchronous active-low reset restores register defaults and empties queue and back.
module morse_text_codec_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  mtc_pkg::t_cfg_index             i_cfg_index,
    input  logic [mtc_pkg::CfgDataW-1:0]    i_cfg_data,
    output logic                            o_cfg_ready,
    input  logic                            push,
    input  mtc_pkg::t_in_word               i_data,
    output logic                            full,
    input  logic                            pop,
    output mtc_pkg::t_out_word              o_data,
    output logic                            empty
);

    logic          job_push;
    mtc_pkg::t_job job_in;
    logic          q_full;
    logic          q_empty;
    logic          job_pop;
    mtc_pkg::t_job job_out;

    mtc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_push      (push),
        .i_data      (i_data),
        .i_q_full    (q_full),
        .o_job_push  (job_push),
        .o_job       (job_in)
    );

    mtc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (q_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (q_empty)
    );

    mtc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_data      (o_data),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign full = q_full;

endmodule

### sv/mtc_queue.sv
// Short job queue between the front and the back of the Morse text codec.
module mtc_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mtc_pkg::t_job  i_data,
    output logic           o_full,
    input  logic           i_pop,
    output mtc_pkg::t_job  o_data,
    output logic           o_empty
);

    mtc_pkg::t_job r_mem [mtc_pkg::QueueDepth];
    logic [mtc_pkg::QueuePtrW-1:0] r_wr_ptr;
    logic [mtc_pkg::QueuePtrW-1:0] r_rd_ptr;
    logic [mtc_pkg::QueuePtrW:0]   r_count;
    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (mtc_pkg::QueuePtrW+1)'(mtc_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/mtc_front.sv
// Front of the Morse text codec: configuration, message state and job building.
module mtc_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  mtc_pkg::t_cfg_index             i_cfg_index,
    input  logic [mtc_pkg::CfgDataW-1:0]    i_cfg_data,
    output logic                            o_cfg_ready,
    input  logic                            i_push,
    input  mtc_pkg::t_in_word               i_data,
    input  logic                            i_q_full,
    output logic                            o_job_push,
    output mtc_pkg::t_job                   o_job
);

    logic        r_mode;
    logic [15:0] r_max;
    logic [7:0]  r_err;

    logic [mtc_pkg::MaxCodeLen-1:0] r_pbits, n_pbits;
    logic [mtc_pkg::LenW-1:0]       r_plen, n_plen;
    logic        r_off, n_off;
    logic        r_inside, n_inside;
    logic [15:0] r_wc, n_wc;
    logic        r_unk, n_unk;
    logic        r_ovf, n_ovf;
    logic        r_ce, n_ce;
    logic        r_emitted, n_emitted;

    logic [7:0] b;
    logic       is_zero, is_space, is_dot, is_dash;
    logic       dec, enc, do_close, accept;
    logic       emit_char, emit_code;
    logic [7:0] char_byte;
    logic [mtc_pkg::PathIdxW-1:0] path_idx;
    mtc_pkg::t_path_entry ent;
    mtc_pkg::t_code code;
    logic [mtc_pkg::LenW:0] need;

    assign o_cfg_ready = 1'b1;
    assign accept      = i_push && !i_q_full;

    assign b        = i_data.in_byte;
    assign is_zero  = (b == mtc_pkg::ChNul);
    assign is_space = (b == mtc_pkg::ChSpace);
    assign is_dot   = (b == mtc_pkg::ChDot);
    assign is_dash  = (b == mtc_pkg::ChDash);
    assign dec      = !r_mode && !r_ce;
    assign enc      = r_mode && !r_ce;
    assign do_close = !r_mode && ((!r_ce && (is_zero || is_space)) || i_data.in_last);
    assign code     = mtc_pkg::code_of(b);
    assign need     = {1'b0, code.len} + (mtc_pkg::LenW+1)'(r_emitted);

    always_comb begin
        n_pbits   = r_pbits;
        n_plen    = r_plen;
        n_off     = r_off;
        n_inside  = r_inside;
        n_wc      = r_wc;
        n_unk     = r_unk;
        n_ovf     = r_ovf;
        n_ce      = r_ce || is_zero;
        n_emitted = r_emitted;
        emit_char = 1'b0;
        emit_code = 1'b0;
        char_byte = mtc_pkg::ChNul;
        path_idx  = '0;
        ent       = '0;

        if (dec && !is_zero && !is_space) begin
            n_inside = 1'b1;
            if ((is_dot || is_dash) && !r_off) begin
                if (r_plen >= mtc_pkg::LenW'(mtc_pkg::MaxCodeLen)) begin
                    n_off = 1'b1;
                end else begin
                    if (is_dash) begin
                        n_pbits[r_plen[mtc_pkg::BitIdxW-1:0]] = 1'b1;
                    end
                    n_plen = r_plen + 1'b1;
                end
            end
        end

        path_idx = (mtc_pkg::PathIdxW'(1) << n_plen) | mtc_pkg::PathIdxW'(n_pbits);
        ent = mtc_pkg::PathTab[path_idx];

        if (do_close && n_inside) begin
            if (!r_ovf) begin
                if (r_wc >= r_max) begin
                    n_ovf = 1'b1;
                end else begin
                    emit_char = 1'b1;
                    n_wc = r_wc + 16'd1;
                    if (n_off || !ent.exists) begin
                        char_byte = mtc_pkg::ChOffTable;
                    end else if (ent.ch == '0) begin
                        char_byte = r_err;
                        n_unk = 1'b1;
                    end else begin
                        char_byte = {1'b0, ent.ch};
                    end
                end
            end
            n_pbits  = '0;
            n_plen   = '0;
            n_off    = 1'b0;
            n_inside = 1'b0;
        end

        if (enc && !is_zero && !b[7] && !r_ovf && code.len != '0) begin
            if ({1'b0, r_wc} + 17'(need) > {1'b0, r_max}) begin
                n_ovf = 1'b1;
            end else begin
                emit_code = 1'b1;
                n_wc = r_wc + 16'(need);
                n_emitted = 1'b1;
            end
        end

        o_job.has_char  = emit_char;
        o_job.char_byte = char_byte;
        o_job.sep       = emit_code && r_emitted;
        o_job.code      = emit_code ? code : '0;
        o_job.has_end   = i_data.in_last;
        o_job.status    = n_ovf ? mtc_pkg::StatusOverflow :
                          (n_unk ? mtc_pkg::StatusUnknown : mtc_pkg::StatusOk);

        if (i_data.in_last) begin
            n_pbits   = '0;
            n_plen    = '0;
            n_off     = 1'b0;
            n_inside  = 1'b0;
            n_wc      = '0;
            n_unk     = 1'b0;
            n_ovf     = 1'b0;
            n_ce      = 1'b0;
            n_emitted = 1'b0;
        end
    end

    assign o_job_push = accept && (emit_char || emit_code || i_data.in_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mtc_pkg::ModeReset;
            r_max  <= mtc_pkg::MaxLengthReset;
            r_err  <= mtc_pkg::ErrorCharReset;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mtc_pkg::CfgMode:      r_mode <= i_cfg_data[0];
                mtc_pkg::CfgMaxLength: r_max  <= i_cfg_data;
                mtc_pkg::CfgErrorChar: r_err  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits   <= '0;
            r_plen    <= '0;
            r_off     <= 1'b0;
            r_inside  <= 1'b0;
            r_wc      <= '0;
            r_unk     <= 1'b0;
            r_ovf     <= 1'b0;
            r_ce      <= 1'b0;
            r_emitted <= 1'b0;
        end else if (accept) begin
            r_pbits   <= n_pbits;
            r_plen    <= n_plen;
            r_off     <= n_off;
            r_inside  <= n_inside;
            r_wc      <= n_wc;
            r_unk     <= n_unk;
            r_ovf     <= n_ovf;
            r_ce      <= n_ce;
            r_emitted <= n_emitted;
        end
    end

endmodule

### sv/mtc_back.sv
// Back of the Morse text codec: expands jobs into output words one per cycle while the output is free.
module mtc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  mtc_pkg::t_job         i_job,
    output logic                  o_job_pop,
    output mtc_pkg::t_out_word    o_data,
    output logic                  o_empty,
    input  logic                  i_pop
);

    mtc_pkg::t_job      r_job, n_job;
    mtc_pkg::t_job      rem;
    mtc_pkg::t_out_word r_out;
    mtc_pkg::t_out_word w;
    logic r_out_full;
    logic live, rem_live, load;

    function automatic logic job_live(input mtc_pkg::t_job j);
        return j.has_char || j.sep || (j.code.len != '0) || j.has_end;
    endfunction

    assign live = job_live(r_job);
    assign load = live && (!r_out_full || i_pop);

    always_comb begin
        rem = r_job;
        w   = '0;
        if (r_job.has_char) begin
            w.out_byte   = r_job.char_byte;
            w.out_valid  = 1'b1;
            rem.has_char = 1'b0;
        end else if (r_job.sep) begin
            w.out_byte  = mtc_pkg::ChSpace;
            w.out_valid = 1'b1;
            rem.sep     = 1'b0;
        end else if (r_job.code.len != '0) begin
            w.out_byte    = r_job.code.bits[0] ? mtc_pkg::ChDash : mtc_pkg::ChDot;
            w.out_valid   = 1'b1;
            rem.code.bits = r_job.code.bits >> 1;
            rem.code.len  = r_job.code.len - 1'b1;
        end else begin
            w.out_last   = 1'b1;
            w.out_status = r_job.status;
            rem.has_end  = 1'b0;
        end
    end

    assign rem_live  = job_live(rem);
    assign o_job_pop = i_job_valid && (!live || (load && !rem_live));

    always_comb begin
        if (o_job_pop) begin
            n_job = i_job;
        end else if (load) begin
            n_job = rem;
        end else begin
            n_job = r_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job      <= '0;
            r_out_full <= 1'b0;
        end else begin
            r_job <= n_job;
            if (load) begin
                r_out_full <= 1'b1;
            end else if (i_pop) begin
                r_out_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= w;
        end
    end

    assign o_data  = r_out;
    assign o_empty = !r_out_full;

endmodule

### verif/tb_morse_text_codec_top.sv
// Self-checking testbench of the Morse text codec: directed words, then random messages.
module tb_morse_text_codec_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DrainCycles = 16;
    localparam int StallLimit  = 4000;
    localparam int PhaseWords  = 40;

    typedef enum logic {RowWord, RowReg} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        mtc_pkg::t_in_word   w;
        mtc_pkg::t_cfg_index idx;
        logic [15:0]         val;
        int                  n_typed;
        mtc_pkg::t_out_word  typed_a;
        mtc_pkg::t_out_word  typed_b;
    } t_bench_row;

    logic                         i_clk       = 1'b0;
    logic                         i_rst_n     = 1'b0;
    logic                         i_cfg_valid = 1'b0;
    mtc_pkg::t_cfg_index          i_cfg_index = mtc_pkg::CfgMode;
    logic [mtc_pkg::CfgDataW-1:0] i_cfg_data  = '0;
    logic                         o_cfg_ready;
    logic                         push        = 1'b0;
    mtc_pkg::t_in_word            i_data      = '0;
    logic                         full;
    logic                         pop         = 1'b0;
    mtc_pkg::t_out_word           o_data;
    logic                         empty;

    string       morse_of[mtc_pkg::TableEntries];
    logic        mode_r;
    logic [15:0] max_len_r;
    logic [7:0]  err_char_r;
    logic [6:0]  sym_bits;
    int          sym_count;
    bit          path_lost;
    bit          token_open;
    bit          saw_unknown;
    bit          saw_overflow;
    bit          body_done;
    bit          code_sent;
    logic [15:0] out_count;

    mtc_pkg::t_out_word awaited_words[$];
    mtc_pkg::t_in_word  msg_words[$];
    t_bench_row         bench_rows[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;
    int sender_idle[4]    = '{0, 69, 0, 18};
    int receiver_stall[4] = '{0, 0, 69, 18};

    morse_text_codec_top i_dut (.*);

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        morse_of[33] = "-.-.--";  morse_of[34] = ".-..-.";  morse_of[36] = "...-..-";
        morse_of[38] = ".-...";   morse_of[39] = ".----.";  morse_of[40] = "-.--.";
        morse_of[41] = "-.--.-";  morse_of[43] = ".-.-.";   morse_of[44] = "--..--";
        morse_of[45] = "-....-";  morse_of[46] = ".-.-.-";  morse_of[47] = "-..-.";
        morse_of[48] = "-----";   morse_of[49] = ".----";   morse_of[50] = "..---";
        morse_of[51] = "...--";   morse_of[52] = "....-";   morse_of[53] = ".....";
        morse_of[54] = "-....";   morse_of[55] = "--...";   morse_of[56] = "---..";
        morse_of[57] = "----.";   morse_of[58] = "---...";  morse_of[59] = "-.-.-.";
        morse_of[61] = "-...-";   morse_of[63] = "..--..";  morse_of[64] = ".--.-.";
        morse_of[65] = ".-";      morse_of[66] = "-...";    morse_of[67] = "-.-.";
        morse_of[68] = "-..";     morse_of[69] = ".";       morse_of[70] = "..-.";
        morse_of[71] = "--.";     morse_of[72] = "....";    morse_of[73] = "..";
        morse_of[74] = ".---";    morse_of[75] = "-.-";     morse_of[76] = ".-..";
        morse_of[77] = "--";      morse_of[78] = "-.";      morse_of[79] = "---";
        morse_of[80] = ".--.";    morse_of[81] = "--.-";    morse_of[82] = ".-.";
        morse_of[83] = "...";     morse_of[84] = "-";       morse_of[85] = "..-";
        morse_of[86] = "...-";    morse_of[87] = ".--";     morse_of[88] = "-..-";
        morse_of[89] = "-.--";    morse_of[90] = "--..";    morse_of[95] = "..--.-";
    end

    function automatic string code_str(input logic [7:0] b);
        logic [7:0] u;
        u = b;
        if (u >= mtc_pkg::ChLowerA && u <= mtc_pkg::ChLowerZ) begin
            u = u - mtc_pkg::CaseOffset;
        end
        return morse_of[u[6:0]];
    endfunction

    function automatic mtc_pkg::t_in_word in_word(input logic [7:0] b, input logic last);
        return mtc_pkg::t_in_word'{in_byte: b, in_last: last};
    endfunction

    function automatic mtc_pkg::t_out_word data_word(input logic [7:0] b);
        return mtc_pkg::t_out_word'{out_byte: b, out_valid: 1'b1, out_last: 1'b0,
                                    out_status: mtc_pkg::StatusOk};
    endfunction

    function automatic mtc_pkg::t_out_word end_word(input mtc_pkg::t_status s);
        return mtc_pkg::t_out_word'{out_byte: mtc_pkg::ChNul, out_valid: 1'b0,
                                    out_last: 1'b1, out_status: s};
    endfunction

    function automatic void drop_message_state();
        sym_bits     = '0;
        sym_count    = 0;
        path_lost    = 1'b0;
        token_open   = 1'b0;
        out_count    = '0;
        saw_unknown  = 1'b0;
        saw_overflow = 1'b0;
        body_done    = 1'b0;
        code_sent    = 1'b0;
    endfunction

    function automatic logic [7:0] resolve_path();
        string      c;
        bit         reachable;
        bit         agrees;
        logic [7:0] hit;
        reachable = 1'b0;
        hit = '0;
        if (path_lost) begin
            return mtc_pkg::ChOffTable;
        end
        for (int b = 0; b < mtc_pkg::TableEntries; b++) begin
            c = code_str(8'(b));
            if (c.len() == 0 || c.len() < sym_count) begin
                continue;
            end
            agrees = 1'b1;
            for (int k = 0; k < sym_count; k++) begin
                if ((c[k] == mtc_pkg::ChDash) != sym_bits[k]) begin
                    agrees = 1'b0;
                end
            end
            if (agrees) begin
                reachable = 1'b1;
                if (c.len() == sym_count) begin
                    hit = 8'(b);
                end
            end
        end
        if (!reachable) begin
            return mtc_pkg::ChOffTable;
        end
        if (hit == '0) begin
            saw_unknown = 1'b1;
            return err_char_r;
        end
        return hit;
    endfunction

    function automatic int seal_token();
        int n;
        n = 0;
        if (!token_open) begin
            return 0;
        end
        if (!saw_overflow) begin
            if (out_count >= max_len_r) begin
                saw_overflow = 1'b1;
            end else begin
                awaited_words.push_back(data_word(resolve_path()));
                out_count++;
                n = 1;
            end
        end
        sym_bits   = '0;
        sym_count  = 0;
        path_lost  = 1'b0;
        token_open = 1'b0;
        return n;
    endfunction

    // Works out the words that one accepted input word causes and queues them.
    function automatic int translate_word(input mtc_pkg::t_in_word w);
        logic [7:0]       b;
        string            c;
        int               need;
        int               n;
        mtc_pkg::t_status s;
        b = w.in_byte;
        n = 0;
        if (!body_done) begin
            if (mode_r == 1'b0) begin
                if (b == mtc_pkg::ChNul) begin
                    n += seal_token();
                    body_done = 1'b1;
                end else if (b == mtc_pkg::ChSpace) begin
                    n += seal_token();
                end else begin
                    token_open = 1'b1;
                    if ((b == mtc_pkg::ChDot || b == mtc_pkg::ChDash) && !path_lost) begin
                        if (sym_count >= mtc_pkg::MaxCodeLen) begin
                            path_lost = 1'b1;
                        end else begin
                            sym_bits[sym_count] = (b == mtc_pkg::ChDash);
                            sym_count++;
                        end
                    end
                end
            end else if (b == mtc_pkg::ChNul) begin
                body_done = 1'b1;
            end else if (b < mtc_pkg::TableEntries && !saw_overflow) begin
                c = code_str(b);
                need = c.len() + (code_sent ? 1 : 0);
                if (c.len() != 0) begin
                    if (int'(out_count) + need > int'(max_len_r)) begin
                        saw_overflow = 1'b1;
                    end else begin
                        if (code_sent) begin
                            awaited_words.push_back(data_word(mtc_pkg::ChSpace));
                            n++;
                        end
                        for (int k = 0; k < c.len(); k++) begin
                            awaited_words.push_back(data_word(8'(c[k])));
                            n++;
                        end
                        out_count = out_count + 16'(need);
                        code_sent = 1'b1;
                    end
                end
            end
        end
        if (w.in_last) begin
            if (mode_r == 1'b0) begin
                n += seal_token();
            end
            s = saw_overflow ? mtc_pkg::StatusOverflow :
                (saw_unknown ? mtc_pkg::StatusUnknown : mtc_pkg::StatusOk);
            awaited_words.push_back(end_word(s));
            n++;
            drop_message_state();
        end
        return n;
    endfunction

    function automatic void add_checked(input logic [7:0] b, input logic last, input int n,
                                        input mtc_pkg::t_out_word ea = '0,
                                        input mtc_pkg::t_out_word eb = '0);
        t_bench_row row;
        row.kind    = RowWord;
        row.w       = in_word(b, last);
        row.idx     = mtc_pkg::CfgMode;
        row.val     = '0;
        row.n_typed = n;
        row.typed_a = ea;
        row.typed_b = eb;
        bench_rows.push_back(row);
    endfunction

    function automatic void add_word(input logic [7:0] b, input logic last);
        add_checked(b, last, 0);
    endfunction

    function automatic void add_reg(input mtc_pkg::t_cfg_index idx, input logic [15:0] val);
        t_bench_row row;
        row.kind    = RowReg;
        row.w       = '0;
        row.idx     = idx;
        row.val     = val;
        row.n_typed = 0;
        row.typed_a = '0;
        row.typed_b = '0;
        bench_rows.push_back(row);
    endfunction

    function automatic void fill_bench_rows();
        add_word(mtc_pkg::ChDot, 1'b0);
        add_word(mtc_pkg::ChDash, 1'b0);
        add_checked(mtc_pkg::ChNul, 1'b0, 1, data_word("a"));
        add_checked(mtc_pkg::ChDash, 1'b1, 1, end_word(mtc_pkg::StatusOk));
        add_checked(mtc_pkg::ChSpace, 1'b1, 1, end_word(mtc_pkg::StatusOk));
        add_checked("x", 1'b1, 2, data_word(mtc_pkg::ErrorCharReset),
                    end_word(mtc_pkg::StatusUnknown));
        add_word(mtc_pkg::ChDot, 1'b0);
        add_word(mtc_pkg::ChDot, 1'b0);
        add_word(mtc_pkg::ChDash, 1'b0);
        add_checked(mtc_pkg::ChDash, 1'b1, 2, data_word(mtc_pkg::ErrorCharReset),
                    end_word(mtc_pkg::StatusUnknown));
        add_word(mtc_pkg::ChDash, 1'b0);
        add_word(mtc_pkg::ChDash, 1'b0);
        add_word(mtc_pkg::ChDot, 1'b0);
        add_word(mtc_pkg::ChDash, 1'b0);
        add_checked(mtc_pkg::ChDash, 1'b1, 2, data_word(mtc_pkg::ChOffTable),
                    end_word(mtc_pkg::StatusOk));
        for (int i = 0; i < mtc_pkg::MaxCodeLen; i++) begin
            add_word(mtc_pkg::ChDot, 1'b0);
        end
        add_checked(mtc_pkg::ChDot, 1'b1, 2, data_word(mtc_pkg::ChOffTable),
                    end_word(mtc_pkg::StatusOk));
        add_reg(mtc_pkg::CfgMode, 16'd1);
        add_reg(mtc_pkg::CfgErrorChar, 16'h00ff);
        add_word(8'hff, 1'b0);
        add_word("0", 1'b1);
        add_reg(mtc_pkg::CfgMaxLength, 16'd0);
        add_checked("e", 1'b1, 1, end_word(mtc_pkg::StatusOverflow));
        add_reg(mtc_pkg::CfgMaxLength, 16'hffff);
        add_word("e", 1'b0);
        add_reg(mtc_pkg::CfgMode, 16'd0);
        add_word(mtc_pkg::ChDot, 1'b1);
    endfunction

    function automatic logic [7:0] pick_coded();
        logic [7:0] b;
        string      c;
        do begin
            b = 8'($urandom_range(33, 95));
            c = code_str(b);
        end while (c.len() == 0);
        if (b >= 8'h41 && b <= 8'h5a && $urandom_range(0, 1) == 1) begin
            b = b + mtc_pkg::CaseOffset;
        end
        return b;
    endfunction

    function automatic void make_decode_msg();
        int    ntok;
        int    kind;
        string c;
        msg_words.delete();
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 8)) begin
                msg_words.push_back(in_word(8'($urandom_range(0, 255)), 1'b0));
            end
        end else begin
            ntok = $urandom_range(1, 5);
            for (int t = 0; t < ntok; t++) begin
                kind = $urandom_range(0, 19);
                if (kind < 14) begin
                    c = code_str(pick_coded());
                    for (int k = 0; k < c.len(); k++) begin
                        msg_words.push_back(in_word(8'(c[k]), 1'b0));
                    end
                end else if (kind < 19) begin
                    repeat ($urandom_range(1, 9)) begin
                        msg_words.push_back(in_word($urandom_range(0, 1) ?
                                                    mtc_pkg::ChDash : mtc_pkg::ChDot, 1'b0));
                    end
                    if (kind == 18) begin
                        msg_words.push_back(in_word(8'($urandom_range(1, 255)), 1'b0));
                    end
                end else begin
                    msg_words.push_back(in_word(mtc_pkg::ChNul, 1'b0));
                end
                if (t < ntok - 1 || $urandom_range(0, 1) == 1) begin
                    repeat ($urandom_range(1, 2)) begin
                        msg_words.push_back(in_word(mtc_pkg::ChSpace, 1'b0));
                    end
                end
            end
        end
        msg_words[$].in_last = 1'b1;
    endfunction

    function automatic void make_encode_msg();
        int kind;
        msg_words.delete();
        repeat ($urandom_range(1, 10)) begin
            kind = $urandom_range(0, 19);
            if (kind < 15) begin
                msg_words.push_back(in_word(pick_coded(), 1'b0));
            end else if (kind < 19) begin
                msg_words.push_back(in_word(8'($urandom_range(1, 255)), 1'b0));
            end else begin
                msg_words.push_back(in_word(mtc_pkg::ChNul, 1'b0));
            end
        end
        msg_words[$].in_last = 1'b1;
    endfunction

    function automatic logic [15:0] pick_capacity();
        case ($urandom_range(0, 5))
            0: begin
                return 16'd0;
            end
            1: begin
                return 16'd1;
            end
            2: begin
                return 16'hffff;
            end
            3: begin
                return mtc_pkg::MaxLengthReset;
            end
            4: begin
                return 16'($urandom_range(2, 12));
            end
            default: begin
                return 16'($urandom_range(13, 60));
            end
        endcase
    endfunction

    function automatic logic [15:0] pick_error_char();
        case ($urandom_range(0, 3))
            0: begin
                return 16'h0000;
            end
            1: begin
                return 16'h00ff;
            end
            default: begin
                return 16'($urandom_range(0, 255));
            end
        endcase
    endfunction

    task automatic send_word(input mtc_pkg::t_in_word w, output int made);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_data <= w;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        made = translate_word(w);
    endtask

    task automatic write_reg(input mtc_pkg::t_cfg_index idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            mtc_pkg::CfgMode: begin
                mode_r = val[0];
            end
            mtc_pkg::CfgMaxLength: begin
                max_len_r = val;
            end
            default: begin
                err_char_r = val[7:0];
            end
        endcase
        @(negedge i_clk);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (awaited_words.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin : check_words
        mtc_pkg::t_out_word want;
        if (i_rst_n && pop && !empty) begin
            if (awaited_words.size() == 0) begin
                $error("unexpected word: actual %p", o_data);
                fail_count++;
            end else begin
                want = awaited_words.pop_front();
                if (o_data.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, actual %0h", want.out_byte, o_data.out_byte);
                    fail_count++;
                end
                if (o_data.out_valid !== want.out_valid) begin
                    $error("out_valid: expected %0b, actual %0b", want.out_valid,
                           o_data.out_valid);
                    fail_count++;
                end
                if (o_data.out_last !== want.out_last) begin
                    $error("out_last: expected %0b, actual %0b", want.out_last, o_data.out_last);
                    fail_count++;
                end
                if (o_data.out_status !== want.out_status) begin
                    $error("out_status: expected %0d, actual %0d", want.out_status,
                           o_data.out_status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= StallLimit) begin
            $display("tb_morse_text_codec_top: FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int made;
        int sent;
        mode_r     = mtc_pkg::ModeReset;
        max_len_r  = mtc_pkg::MaxLengthReset;
        err_char_r = mtc_pkg::ErrorCharReset;
        drop_message_state();
        fill_bench_rows();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (bench_rows[r]) begin
            if (bench_rows[r].kind == RowReg) begin
                settle();
                write_reg(bench_rows[r].idx, bench_rows[r].val);
            end else begin
                send_word(bench_rows[r].w, made);
                if (bench_rows[r].n_typed != 0) begin
                    repeat (made) void'(awaited_words.pop_back());
                    awaited_words.push_back(bench_rows[r].typed_a);
                    if (bench_rows[r].n_typed == 2) begin
                        awaited_words.push_back(bench_rows[r].typed_b);
                    end
                end
            end
        end

        // Each idling profile is run once per mode, with a fresh register setting.
        for (int p = 0; p < 8; p++) begin
            settle();
            write_reg(mtc_pkg::CfgMode, 16'(p % 2));
            write_reg(mtc_pkg::CfgMaxLength, pick_capacity());
            write_reg(mtc_pkg::CfgErrorChar, pick_error_char());
            send_idle_pct  = sender_idle[p / 2];
            recv_stall_pct = receiver_stall[p / 2];
            sent = 0;
            while (sent < PhaseWords) begin
                if (mode_r) begin
                    make_encode_msg();
                end else begin
                    make_decode_msg();
                end
                foreach (msg_words[i]) begin
                    send_word(msg_words[i], made);
                end
                sent += msg_words.size();
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("tb_morse_text_codec_top: PASS");
        end else begin
            $display("tb_morse_text_codec_top: FAIL");
        end
        $finish;
    end

endmodule

### sim.f
sv/mtc_pkg.sv
sv/mtc_queue.sv
sv/mtc_front.sv
sv/mtc_back.sv
sv/morse_text_codec_top.sv
verif/tb_morse_text_codec_top.sv
